// File: rtl/pid_filtered_derivative_lpf_core_defines.svh
// ---------------------------------------------------------------------------
// PID core assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef PID_FILTERED_DERIVATIVE_LPF_CORE_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_LPF_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// next-cycle implication
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define PFD_ASSERT_SAME(label, clk, rst, ante, cons)
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/pfd_pkg.sv
// ---------------------------------------------------------------------------
// PID core package
// Types, codes, filter coefficients and the microcode program.
// ---------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int ACC_W          = 44;  // holds any shifted product or sum
   localparam int MUL_W          = 33;  // signed multiplier operand width
   localparam int PROD_W         = 2 * MUL_W;
   localparam int STEP_W         = 4;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN,
      CSR_INTEG_GAIN,
      CSR_DERIV_POLE,
      CSR_DERIV_GAIN,
      CSR_OUT_OFFSET,
      CSR_INTEGRAL_LIMIT,
      CSR_OUTPUT_LIMIT,
      CSR_FILTER_MODE
   } csr_index_type;

   typedef struct packed {
      logic [31:0] prop_gain;
      logic [31:0] integ_gain;
      logic [23:0] deriv_pole;
      logic [31:0] deriv_gain;
      logic [31:0] out_offset;
      logic [30:0] integral_limit;
      logic [30:0] output_limit;
      logic [2:0]  filter_mode;
   } cfg_type;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      A_PROP, A_INTEG, A_POLE, A_DGAIN, A_COEFA, A_COEFB
   } a_sel_type;

   typedef enum logic [2:0] {
      B_ERR, B_ESUM, B_EDIF, B_DACC, B_FILT, B_RSUM
   } b_sel_type;

   typedef enum logic [1:0] {
      OPND_NONE, OPND_INTEG, OPND_DERIV, OPND_OFFSET
   } opnd_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_INTEG, WB_DERIV, WB_RAW, WB_FILT, WB_PASS, WB_CLEAR
   } wb_type;

   typedef enum logic [1:0] {
      BR_NEXT, BR_SKIP, BR_DONE
   } br_type;

   typedef struct packed {
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      sh30;      // shift product by 30, else by 24
      logic      acc_keep;  // accumulate onto acc, else start from zero
      logic      use_prod;  // add registered product
      opnd_type  opnd;
      wb_type    wb;
      br_type    br;
      step_type  target;
   } cw_type;

   typedef struct packed {
      cw_type cw;
      logic   fire;   // done step completes, result goes to the output reg
   } seq_ctl_type;

   localparam step_type STEP_FIRST = 4'd0;
   localparam step_type STEP_PASS  = 4'd11;
   localparam step_type STEP_CLEAR = 4'd12;

   function automatic cw_type make_cw(
      input a_sel_type a, input b_sel_type b, input logic sh30,
      input logic keep, input logic prod, input opnd_type opnd,
      input wb_type wb, input br_type br, input step_type target);
      cw_type w;
      w.a_sel    = a;
      w.b_sel    = b;
      w.sh30     = sh30;
      w.acc_keep = keep;
      w.use_prod = prod;
      w.opnd     = opnd;
      w.wb       = wb;
      w.br       = br;
      w.target   = target;
      return w;
   endfunction

   // idle and held done steps leave acc untouched
   localparam cw_type CW_NOP = '{A_PROP, B_ERR, 1'b0, 1'b1, 1'b0, OPND_NONE,
                                 WB_NONE, BR_DONE, STEP_FIRST};

   // Microcode. Products land in prod the step after issue, sums in acc the
   // step after they are formed; write-backs read acc.
   function automatic cw_type ucode_rom(input step_type step);
      cw_type w;
      unique case (step)
         // integral increment
         4'd0:  w = make_cw(A_INTEG, B_ESUM, 1'b0, 1'b0, 1'b0, OPND_NONE,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         // pole * deriv; acc = integral + increment
         4'd1:  w = make_cw(A_POLE, B_DACC, 1'b0, 1'b0, 1'b1, OPND_INTEG,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         // deriv gain * error difference; integral write-back
         4'd2:  w = make_cw(A_DGAIN, B_EDIF, 1'b0, 1'b0, 1'b1, OPND_NONE,
                            WB_INTEG, BR_NEXT, STEP_FIRST);
         // proportional term
         4'd3:  w = make_cw(A_PROP, B_ERR, 1'b0, 1'b1, 1'b1, OPND_NONE,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         // deriv write-back; acc = P + integral
         4'd4:  w = make_cw(A_PROP, B_ERR, 1'b0, 1'b0, 1'b1, OPND_INTEG,
                            WB_DERIV, BR_NEXT, STEP_FIRST);
         4'd5:  w = make_cw(A_PROP, B_ERR, 1'b0, 1'b1, 1'b0, OPND_DERIV,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         4'd6:  w = make_cw(A_PROP, B_ERR, 1'b0, 1'b1, 1'b0, OPND_OFFSET,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         // raw write-back; filter feedback product; skip filter if off
         4'd7:  w = make_cw(A_COEFA, B_FILT, 1'b1, 1'b0, 1'b0, OPND_NONE,
                            WB_RAW, BR_SKIP, STEP_PASS);
         4'd8:  w = make_cw(A_COEFB, B_RSUM, 1'b1, 1'b0, 1'b1, OPND_NONE,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         4'd9:  w = make_cw(A_PROP, B_ERR, 1'b0, 1'b1, 1'b1, OPND_NONE,
                            WB_NONE, BR_NEXT, STEP_FIRST);
         4'd10: w = make_cw(A_PROP, B_ERR, 1'b0, 1'b0, 1'b0, OPND_NONE,
                            WB_FILT, BR_DONE, STEP_FIRST);
         4'd11: w = make_cw(A_PROP, B_ERR, 1'b0, 1'b0, 1'b0, OPND_NONE,
                            WB_PASS, BR_DONE, STEP_FIRST);
         4'd12: w = make_cw(A_PROP, B_ERR, 1'b0, 1'b0, 1'b0, OPND_NONE,
                            WB_CLEAR, BR_DONE, STEP_FIRST);
         default: w = CW_NOP;
      endcase
      return w;
   endfunction

   function automatic logic filter_on(input logic [2:0] mode);
      return (mode >= 3'd1) && (mode <= 3'd4);
   endfunction

   // Q2.30 low-pass coefficients
   function automatic logic signed [MUL_W-1:0] coef_a(input logic [2:0] mode);
      logic signed [MUL_W-1:0] c;
      unique case (mode)
         3'd1:    c = 33'sd1053690652;
         3'd2:    c = 33'sd1066346181;
         3'd3:    c = 33'sd1068358128;
         3'd4:    c = 33'sd1070373852;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [MUL_W-1:0] coef_b(input logic [2:0] mode);
      logic signed [MUL_W-1:0] c;
      unique case (mode)
         3'd1:    c = 33'sd10025586;
         3'd2:    c = 33'sd3697821;
         3'd3:    c = 33'sd2691848;
         3'd4:    c = 33'sd1683986;
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/pfd_useq.sv
// ---------------------------------------------------------------------------
// PID core microsequencer
// Step counter over the microcode ROM with skip and done branches.
// ---------------------------------------------------------------------------
`default_nettype none

module pfd_useq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                op,
   input  wire logic                filt_on,
   input  wire logic                out_full,
   output logic                     busy,
   output pfd_pkg::seq_ctl_type     ctl
);

   logic               busy_ff, busy_in;
   pfd_pkg::step_type  step_ff, step_in;
   pfd_pkg::cw_type    cw_rom;
   logic               at_done;

   assign cw_rom  = pfd_pkg::ucode_rom(step_ff);
   assign at_done = busy_ff && (cw_rom.br == pfd_pkg::BR_DONE);

   // next state
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = (op == pfd_pkg::OP_CLEAR) ? pfd_pkg::STEP_CLEAR
                                                : pfd_pkg::STEP_FIRST;
         end
      end else begin
         unique case (cw_rom.br)
            pfd_pkg::BR_NEXT: step_in = step_ff + 4'd1;
            pfd_pkg::BR_SKIP: step_in = filt_on ? step_ff + 4'd1 : cw_rom.target;
            pfd_pkg::BR_DONE: begin
               if (!out_full) begin
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   // outputs: hold the datapath while the done step waits on the output reg
   always_comb begin
      ctl.fire = at_done && !out_full;
      if (busy_ff && !(at_done && out_full)) begin
         ctl.cw = cw_rom;
      end else begin
         ctl.cw = pfd_pkg::CW_NOP;
      end
   end

   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= pfd_pkg::STEP_FIRST;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/pfd_dpath.sv
// ---------------------------------------------------------------------------
// PID core datapath
// Shared 33x33 multiplier, accumulator, clamps and the state words.
// ---------------------------------------------------------------------------
`default_nettype none

module pfd_dpath #(
   parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [31:0]      error_sample,
   input  pfd_pkg::cfg_type      cfg,
   input  pfd_pkg::cw_type       cw,
   output logic [31:0]           filt_next,
   output logic [31:0]           perr_next
);

   localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;  // state word width
   localparam int AW = pfd_pkg::ACC_W;
   localparam int MW = pfd_pkg::MUL_W;
   localparam int PW = pfd_pkg::PROD_W;

   localparam logic signed [AW-1:0] W_MAX = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
   localparam logic signed [AW-1:0] W_MIN = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};

   function automatic logic signed [SW-1:0] sat_w(input logic signed [AW-1:0] x);
      logic signed [SW-1:0] y;
      if (x > W_MAX) begin
         y = W_MAX[SW-1:0];
      end else if (x < W_MIN) begin
         y = W_MIN[SW-1:0];
      end else begin
         y = x[SW-1:0];
      end
      return y;
   endfunction

   function automatic logic signed [SW-1:0] clamp_sat(input logic signed [AW-1:0] x,
                                                     input logic [30:0] lim);
      logic signed [AW-1:0] lp;
      logic signed [AW-1:0] ln;
      logic signed [AW-1:0] y;
      lp = {{(AW-31){1'b0}}, lim};
      ln = -lp;
      if (x > lp) begin
         y = lp;
      end else if (x < ln) begin
         y = ln;
      end else begin
         y = x;
      end
      return sat_w(y);
   endfunction

   function automatic logic signed [MW-1:0] sx_m(input logic signed [SW-1:0] x);
      return {{(MW-SW){x[SW-1]}}, x};
   endfunction

   function automatic logic signed [AW-1:0] sx_a(input logic signed [SW-1:0] x);
      return {{(AW-SW){x[SW-1]}}, x};
   endfunction

   logic signed [SW-1:0] e_ff;
   logic signed [SW-1:0] integ_ff, integ_in;
   logic signed [SW-1:0] deriv_ff, deriv_in;
   logic signed [SW-1:0] perr_ff, perr_in;
   logic signed [SW-1:0] praw_ff, praw_in;
   logic signed [SW-1:0] filt_ff, filt_in;
   logic signed [SW-1:0] raw_ff, raw_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [AW-1:0] prod_ff, prod_in;

   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_full;
   logic signed [PW-1:0] prod_sh;
   logic signed [AW-1:0] opnd_val;
   logic signed [AW-1:0] e_wide;

   // operand select
   always_comb begin
      unique case (cw.a_sel)
         pfd_pkg::A_PROP:  mul_a = {cfg.prop_gain[31], cfg.prop_gain};
         pfd_pkg::A_INTEG: mul_a = {cfg.integ_gain[31], cfg.integ_gain};
         pfd_pkg::A_POLE:  mul_a = {{(MW-24){1'b0}}, cfg.deriv_pole};
         pfd_pkg::A_DGAIN: mul_a = {cfg.deriv_gain[31], cfg.deriv_gain};
         pfd_pkg::A_COEFA: mul_a = pfd_pkg::coef_a(cfg.filter_mode);
         pfd_pkg::A_COEFB: mul_a = pfd_pkg::coef_b(cfg.filter_mode);
         default:          mul_a = '0;
      endcase
      unique case (cw.b_sel)
         pfd_pkg::B_ERR:  mul_b = sx_m(e_ff);
         pfd_pkg::B_ESUM: mul_b = sx_m(e_ff) + sx_m(perr_ff);
         pfd_pkg::B_EDIF: mul_b = sx_m(e_ff) - sx_m(perr_ff);
         pfd_pkg::B_DACC: mul_b = sx_m(deriv_ff);
         pfd_pkg::B_FILT: mul_b = sx_m(filt_ff);
         pfd_pkg::B_RSUM: mul_b = sx_m(praw_ff) + sx_m(raw_ff);
         default:         mul_b = '0;
      endcase
   end

   // floor shift; the result always fits the accumulator width
   assign prod_full = mul_a * mul_b;
   assign prod_sh   = cw.sh30 ? (prod_full >>> 30) : (prod_full >>> 24);
   assign prod_in   = prod_sh[AW-1:0];

   always_comb begin
      unique case (cw.opnd)
         pfd_pkg::OPND_NONE:   opnd_val = '0;
         pfd_pkg::OPND_INTEG:  opnd_val = sx_a(integ_ff);
         pfd_pkg::OPND_DERIV:  opnd_val = sx_a(deriv_ff);
         pfd_pkg::OPND_OFFSET: opnd_val = {{(AW-32){cfg.out_offset[31]}}, cfg.out_offset};
         default:              opnd_val = '0;
      endcase
   end

   assign acc_in = (cw.acc_keep ? acc_ff : '0) + (cw.use_prod ? prod_ff : '0) + opnd_val;

   // state write-back
   always_comb begin
      integ_in = integ_ff;
      deriv_in = deriv_ff;
      perr_in  = perr_ff;
      praw_in  = praw_ff;
      filt_in  = filt_ff;
      raw_in   = raw_ff;
      unique case (cw.wb)
         pfd_pkg::WB_NONE:  ;
         pfd_pkg::WB_INTEG: integ_in = clamp_sat(acc_ff, cfg.integral_limit);
         pfd_pkg::WB_DERIV: deriv_in = sat_w(acc_ff);
         pfd_pkg::WB_RAW: begin
            raw_in  = clamp_sat(acc_ff, cfg.output_limit);
            perr_in = e_ff;
         end
         pfd_pkg::WB_FILT: begin
            filt_in = sat_w(acc_ff);
            praw_in = raw_ff;
         end
         pfd_pkg::WB_PASS: begin
            filt_in = raw_ff;
            praw_in = raw_ff;
         end
         pfd_pkg::WB_CLEAR: begin
            integ_in = '0;
            deriv_in = '0;
            perr_in  = '0;
            praw_in  = '0;
            filt_in  = '0;
         end
         default: ;
      endcase
   end

   assign e_wide    = {{(AW-32){error_sample[31]}}, error_sample};
   assign filt_next = {{(32-SW){filt_in[SW-1]}}, filt_in};
   assign perr_next = {{(32-SW){perr_in[SW-1]}}, perr_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         deriv_ff <= '0;
         perr_ff  <= '0;
         praw_ff  <= '0;
         filt_ff  <= '0;
      end else begin
         integ_ff <= integ_in;
         deriv_ff <= deriv_in;
         perr_ff  <= perr_in;
         praw_ff  <= praw_in;
         filt_ff  <= filt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         e_ff <= sat_w(e_wide);
      end
      raw_ff  <= raw_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// File: rtl/pid_filtered_derivative_lpf_core.sv
// Requests are taken only while idle. A step runs microcode steps 0 to 10
// with the low-pass on, or 0 to 7 and the pass step with it off; a clear runs
// only the clear step. One item at a time on the one shared 33x33 multiplier.
// A result waiting in the output register holds the done step until taken.
// Synchronous active-high reset clears the integral, derivative, error and
// filter state, the CSRs and the sequencer; no clearing pass is needed.
// ---------------------------------------------------------------------------
// PID core with filtered derivative and output low-pass
// Top level: CSR bank, stream handshakes, sequencer and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pid_filtered_derivative_lpf_core_defines.svh"

module pid_filtered_derivative_lpf_core #(
   parameter int DATA_WIDTH = pfd_pkg::DATA_WIDTH_DEF  // saturation width, max 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,    // [31:0] error_sample
   input  wire logic        req_tuser,    // [0] op: 0 step, 1 clear state
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // [31:0] filtered_out, [63:32] last_error
   // register write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   pfd_pkg::cfg_type      cfg_ff, cfg_in;
   pfd_pkg::seq_ctl_type  seq_ctl;
   logic                  busy;
   logic                  start;
   logic                  out_full;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]           rsp_tdata_ff;
   logic [31:0]           filt_next, perr_next;

   // CSR writes are always taken; software writes only while idle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (pfd_pkg::csr_index_type'(csr_addr))
            pfd_pkg::CSR_PROP_GAIN:      cfg_in.prop_gain      = csr_wdata;
            pfd_pkg::CSR_INTEG_GAIN:     cfg_in.integ_gain     = csr_wdata;
            pfd_pkg::CSR_DERIV_POLE:     cfg_in.deriv_pole     = csr_wdata[23:0];
            pfd_pkg::CSR_DERIV_GAIN:     cfg_in.deriv_gain     = csr_wdata;
            pfd_pkg::CSR_OUT_OFFSET:     cfg_in.out_offset     = csr_wdata;
            pfd_pkg::CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wdata[30:0];
            pfd_pkg::CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_wdata[30:0];
            pfd_pkg::CSR_FILTER_MODE:    cfg_in.filter_mode    = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side: a transaction is taken only while the sequencer is idle
   assign req_tready = !busy;
   assign start      = req_tvalid && !busy;

   // output register still holding an untaken result
   assign out_full = rsp_tvalid_ff && !rsp_tready;

   pfd_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .op       (req_tuser),
      .filt_on  (pfd_pkg::filter_on(cfg_ff.filter_mode)),
      .out_full (out_full),
      .busy     (busy),
      .ctl      (seq_ctl)
   );

   pfd_dpath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .error_sample (req_tdata),
      .cfg          (cfg_ff),
      .cw           (seq_ctl.cw),
      .filt_next    (filt_next),
      .perr_next    (perr_next)
   );

   // result register: loaded on the done step, decouples from the consumer
   assign rsp_tvalid_in = seq_ctl.fire || out_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctl.fire) begin
         rsp_tdata_ff <= {perr_next, filt_next};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // an accepted request closes the input in the next cycle
   `PFD_ASSERT_NEXT(a_accept_closes, clock, reset, req_tvalid && req_tready, !req_tready)
   // a finished step always shows up on the response port
   `PFD_ASSERT_NEXT(a_fire_shows, clock, reset, seq_ctl.fire, rsp_tvalid)
   // the done step never fires while a result is still pending, and only while busy
   `PFD_ASSERT_SAME(a_fire_no_clobber, clock, reset, seq_ctl.fire, !out_full && !req_tready)

endmodule

`default_nettype wire
